@@ rtl/sync_framed_packet_encoder_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet encoder
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_PACKET_ENCODER_UNIT_MACROS_SVH
`define SYNC_FRAMED_PACKET_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define SFPE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// expression must never be true outside reset
`define SFPE_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`else

`define SFPE_ASSERT(label, clk, rst, prop, msg)
`define SFPE_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

@@ rtl/sfpe_pkg.sv @@
// ----------------------------------------------------------------------------
// Framed packet encoder package
// Widths, reset values, codes and the CRC-8 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpe_pkg;

   localparam int BYTE_W      = 8;
   localparam int CSR_ADDR_W  = 8;
   localparam int MAX_RESULTS = 5;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h55;
   localparam logic [BYTE_W-1:0] CRC_POLY          = 8'h07;
   localparam logic [BYTE_W-1:0] CRC_INIT          = 8'h00;

   // item opcodes
   typedef enum logic [0:0] {
      OP_START   = 1'b0,
      OP_PAYLOAD = 1'b1
   } op_type;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SYNC_FIRST  = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SYNC_SECOND = 8'd1;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // crc-8, msb first, one byte folded in (unrolled shift/xor network)
   function automatic byte_type crc_fold(input byte_type crc, input byte_type data);
      byte_type v;
      v = crc ^ data;
      for (int b = 0; b < BYTE_W; b++) begin
         if (v[BYTE_W-1]) begin
            v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[BYTE_W-2:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

@@ rtl/sfpe_if.sv @@
// ----------------------------------------------------------------------------
// Framed packet encoder channels
// Valid/ready interfaces for the item, result and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

// input item channel
interface sfpe_req_if;
   import sfpe_pkg::*;

   logic                valid;
   logic                ready;
   logic [0:0]          op;
   logic [BYTE_W-1:0]   msg_kind;
   logic [BYTE_W-1:0]   frame_length;
   logic [BYTE_W-1:0]   payload_byte;

   modport source (output valid, op, msg_kind, frame_length, payload_byte,
                   input ready);
   modport sink   (input valid, op, msg_kind, frame_length, payload_byte,
                   output ready);
endinterface

// result byte channel
interface sfpe_rsp_if;
   import sfpe_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   tx_byte;
   logic                frame_end;

   modport source (output valid, tx_byte, frame_end, input ready);
   modport sink   (input valid, tx_byte, frame_end, output ready);
endinterface

// register write channel
interface sfpe_csr_if;
   import sfpe_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [BYTE_W-1:0]     wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/sync_framed_packet_encoder_unit.sv @@
// The first result beat is valid in the cycle after the item beat is taken.
// A start item yields 4 header beats plus the crc beat when its length is zero;
// a payload item yields its byte plus the crc beat on the last one, or nothing.
// Results leave one beat per cycle from the result register while ready is high;
// the next item is taken when idle or as the last beat leaves; the output paces it.
// Reset: synchronous, active high; clears frame state and restores sync bytes.
// ----------------------------------------------------------------------------
// Sync framed packet encoder
// Builds sync/type/length/payload/crc-8 frames one byte per result beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_framed_packet_encoder_unit_macros.svh"

module sync_framed_packet_encoder_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   sfpe_req_if.sink   req_chan,
   sfpe_rsp_if.source rsp_chan,
   sfpe_csr_if.sink   csr_chan
);
   import sfpe_pkg::*;

   // sync byte registers
   byte_type sync_first_ff,  sync_first_in;
   byte_type sync_second_ff, sync_second_in;

   // frame state
   byte_type crc_ff,  crc_in;
   byte_type left_ff, left_in;
   logic     open_ff, open_in;

   // result group: bytes drained from entry zero, count and end flag
   byte_type grp_ff [MAX_RESULTS];
   byte_type grp_in [MAX_RESULTS];
   cnt_type  cnt_ff, cnt_in;
   logic     end_ff, end_in;

   logic     req_fire;
   logic     rsp_fire;
   logic     last_beat;
   byte_type start_crc;
   byte_type data_crc;
   byte_type left_dec;

   // handshakes
   assign last_beat      = (cnt_ff == cnt_type'(1));
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (cnt_ff == '0) || (rsp_chan.ready && last_beat);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // result outputs
   assign rsp_chan.valid     = (cnt_ff != '0);
   assign rsp_chan.tx_byte   = grp_ff[0];
   assign rsp_chan.frame_end = end_ff && last_beat;

   // crc updates
   assign start_crc = crc_fold(crc_fold(CRC_INIT, req_chan.msg_kind), req_chan.frame_length);
   assign data_crc  = crc_fold(crc_ff, req_chan.payload_byte);
   assign left_dec  = left_ff - byte_type'(1);

   // register writes
   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_chan.valid) begin
         case (csr_chan.addr)
            CSR_SYNC_FIRST:  sync_first_in  = csr_chan.wdata;
            CSR_SYNC_SECOND: sync_second_in = csr_chan.wdata;
            default: ;
         endcase
      end
   end

   // frame state and result group next values
   always_comb begin
      crc_in  = crc_ff;
      left_in = left_ff;
      open_in = open_ff;
      cnt_in  = cnt_ff;
      end_in  = end_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         grp_in[i] = grp_ff[i];
      end

      // drain one beat
      if (rsp_fire) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            grp_in[i] = grp_ff[i+1];
         end
         cnt_in = cnt_ff - cnt_type'(1);
      end

      // new item, group is empty or its last beat leaves now
      if (req_fire) begin
         case (op_type'(req_chan.op))
            OP_START: begin
               grp_in[0] = sync_first_ff;
               grp_in[1] = sync_second_ff;
               grp_in[2] = req_chan.msg_kind;
               grp_in[3] = req_chan.frame_length;
               grp_in[4] = start_crc;
               crc_in    = start_crc;
               left_in   = req_chan.frame_length;
               open_in   = (req_chan.frame_length != '0);
               end_in    = (req_chan.frame_length == '0);
               cnt_in    = (req_chan.frame_length == '0) ? cnt_type'(MAX_RESULTS)
                                                         : cnt_type'(MAX_RESULTS - 1);
            end
            OP_PAYLOAD: begin
               if (open_ff && (left_ff != '0)) begin
                  grp_in[0] = req_chan.payload_byte;
                  grp_in[1] = data_crc;
                  crc_in    = data_crc;
                  left_in   = left_dec;
                  open_in   = (left_dec != '0);
                  end_in    = (left_dec == '0);
                  cnt_in    = (left_dec == '0) ? cnt_type'(2) : cnt_type'(1);
               end else begin
                  // dropped: no frame open
                  open_in = 1'b0;
                  cnt_in  = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
         crc_ff         <= CRC_INIT;
         left_ff        <= '0;
         open_ff        <= 1'b0;
         cnt_ff         <= '0;
         end_ff         <= 1'b0;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
         crc_ff         <= crc_in;
         left_ff        <= left_in;
         open_ff        <= open_in;
         cnt_ff         <= cnt_in;
         end_ff         <= end_in;
      end
   end

   // result bytes
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         grp_ff[i] <= grp_in[i];
      end
   end

   // checks
   `SFPE_ASSERT(a_take_on_last, clock, reset,
      (req_fire && (cnt_ff != '0)) |-> (rsp_fire && last_beat),
      "item taken while result beats still pending")
   `SFPE_ASSERT(a_start_group, clock, reset,
      (req_fire && (req_chan.op == OP_START)) |=>
      ((cnt_ff == cnt_type'(MAX_RESULTS)) || (cnt_ff == cnt_type'(MAX_RESULTS - 1))),
      "start item did not load a header group")
   `SFPE_ASSERT_NEVER(a_open_has_left, clock, reset,
      open_ff && (left_ff == '0),
      "frame open with no payload bytes left")
   `SFPE_ASSERT(a_end_closes, clock, reset,
      (rsp_fire && rsp_chan.frame_end && !req_fire) |-> !open_ff,
      "frame end beat while a frame is still open")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet encoder testbench
// Feeds start and payload items and register writes into the encoder. Random
// idle cycles fall on both sides. Every result beat is checked against a frame
// predictor that holds its own sync bytes, crc-8 and frame state.
// ----------------------------------------------------------------------------

module tb_top;
   import sfpe_pkg::*;

   // frame predictor and store of expected result beats
   class frame_scoreboard;
      typedef struct packed {
         byte_type tx_byte;
         logic     frame_end;
      } beat_type;

      byte_type sync_first;
      byte_type sync_second;
      byte_type crc;
      byte_type bytes_left;
      bit       frame_open;
      beat_type expected_beats[$];
      int       mismatches;

      function new();
         sync_first  = SYNC_FIRST_RESET;
         sync_second = SYNC_SECOND_RESET;
         crc         = CRC_INIT;
         bytes_left  = '0;
         frame_open  = 1'b0;
         mismatches  = 0;
      endfunction

      // bit-serial crc-8, msb first
      function byte_type crc8_update(byte_type crc_in, byte_type data);
         byte_type c;
         logic     fb;
         c = crc_in;
         for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = c[BYTE_W-1] ^ data[i];
            c  = {c[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
         end
         return c;
      endfunction

      function void add_beat(byte_type b, logic fe);
         beat_type bt;
         bt.tx_byte   = b;
         bt.frame_end = fe;
         expected_beats.push_back(bt);
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] addr, byte_type data);
         if (addr == CSR_SYNC_FIRST) begin
            sync_first = data;
         end else if (addr == CSR_SYNC_SECOND) begin
            sync_second = data;
         end
      endfunction

      // returns the number of beats the item causes
      function int note_item(op_type op, byte_type kind, byte_type len, byte_type data);
         int before_cnt;
         before_cnt = expected_beats.size();
         if (op == OP_START) begin
            add_beat(sync_first, 1'b0);
            add_beat(sync_second, 1'b0);
            add_beat(kind, 1'b0);
            add_beat(len, 1'b0);
            crc        = crc8_update(crc8_update(CRC_INIT, kind), len);
            bytes_left = len;
            frame_open = (len != 0);
            if (len == 0) begin
               add_beat(crc, 1'b1);
            end
         end else if (frame_open && bytes_left != 0) begin
            add_beat(data, 1'b0);
            crc        = crc8_update(crc, data);
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0) begin
               add_beat(crc, 1'b1);
               frame_open = 1'b0;
            end
         end else begin
            // stray payload byte, dropped
            frame_open = 1'b0;
         end
         return expected_beats.size() - before_cnt;
      endfunction

      function void check_beat(byte_type tx, logic fe);
         beat_type want;
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected beat tx_byte=%02h frame_end=%0b", $time, tx, fe);
            end
            return;
         end
         want = expected_beats.pop_front();
         if (want.tx_byte !== tx || want.frame_end !== fe) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: beat mismatch: expected tx_byte=%02h frame_end=%0b,",
                        $time, want.tx_byte, want.frame_end);
               $display("   got tx_byte=%02h frame_end=%0b", tx, fe);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   int   items_done = 0;

   frame_scoreboard board = new();

   sfpe_req_if req_chan ();
   sfpe_rsp_if rsp_chan ();
   sfpe_csr_if csr_chan ();

   sync_framed_packet_encoder_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // known values from time zero
   initial begin
      req_chan.valid        = 1'b0;
      req_chan.op           = OP_START;
      req_chan.msg_kind     = '0;
      req_chan.frame_length = '0;
      req_chan.payload_byte = '0;
      rsp_chan.ready        = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.addr         = '0;
      csr_chan.wdata        = '0;
   end

   // one item beat, preceded by a random idle gap
   task automatic send_item(input op_type op, input byte_type kind, input byte_type len,
                            input byte_type data);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.op           <= op;
      req_chan.msg_kind     <= kind;
      req_chan.frame_length <= len;
      req_chan.payload_byte <= data;
      do @(posedge clock); while (!req_chan.ready);
      if (board.note_item(op, kind, len, data) > 0) begin
         items_done++;
      end
   endtask

   // payload_byte is don't-care on a start item, so it gets noise
   task automatic send_start(input byte_type kind, input byte_type len);
      send_item(OP_START, kind, len, byte_type'($urandom));
   endtask

   // msg_kind and frame_length are don't-care on a payload item
   task automatic send_payload(input byte_type data);
      send_item(OP_PAYLOAD, byte_type'($urandom), byte_type'($urandom), data);
   endtask

   // start item followed by count random payload beats
   task automatic send_frame(input byte_type kind, input byte_type len, input int count);
      send_start(kind, len);
      repeat (count) send_payload(byte_type'($urandom));
   endtask

   // register write; keep holds valid high for a following write
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input byte_type data,
                            input bit keep);
      csr_chan.valid <= 1'b1;
      csr_chan.addr  <= addr;
      csr_chan.wdata <= data;
      do @(posedge clock); while (!csr_chan.ready);
      board.write_reg(addr, data);
      if (!keep) begin
         csr_chan.valid <= 1'b0;
      end
   endtask

   // hold off the sender until every expected beat has arrived
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (board.expected_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result sink with random stalls
   initial begin
      int stall;
      wait (reset === 1'b0);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         board.check_beat(rsp_chan.tx_byte, rsp_chan.frame_end);
      end
   end

   // stimulus
   initial begin
      int       goal;
      int       choice;
      byte_type len;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // zero length frames at reset sync values, stray payload in between
      send_start(8'h00, 8'h00);
      send_payload(8'hFF);
      send_start(8'hFF, 8'h00);
      // short frame, then a payload after it closed
      send_frame(8'h5A, 8'd3, 0);
      send_payload(8'h00);
      send_payload(8'hFF);
      send_payload(8'h81);
      send_payload(8'h3C);
      // start during an open frame abandons it
      send_start(8'hC3, 8'd4);
      send_payload(8'h11);
      send_start(8'h01, 8'd1);
      send_payload(8'hA5);
      send_frame(8'h80, 8'hFF, 2);
      send_frame(8'h7E, 8'd2, 2);
      wait_idle();

      // extreme sync bytes, out-of-range indexes ignored
      write_csr(CSR_SYNC_FIRST, 8'h00, 1'b1);
      write_csr(CSR_SYNC_SECOND, 8'hFF, 1'b1);
      write_csr(8'd2, 8'h12, 1'b1);
      write_csr(8'hFF, 8'h34, 1'b0);
      send_frame(8'h42, 8'd1, 1);
      wait_idle();

      write_csr(CSR_SYNC_FIRST, 8'hFF, 1'b1);
      write_csr(CSR_SYNC_SECOND, 8'h00, 1'b0);
      send_start(8'h24, 8'h00);
      send_frame(8'h99, 8'd2, 2);
      wait_idle();

      // random frames in three register settings
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            write_csr(CSR_SYNC_FIRST, SYNC_FIRST_RESET, 1'b1);
            write_csr(CSR_SYNC_SECOND, SYNC_SECOND_RESET, 1'b0);
         end else begin
            write_csr(CSR_SYNC_FIRST, byte_type'($urandom), 1'b1);
            write_csr(CSR_SYNC_SECOND, byte_type'($urandom), 1'b0);
         end
         goal = items_done + 40;
         while (items_done < goal) begin
            if ($urandom_range(0, 4) == 0) begin
               quiet = ~quiet;
            end
            choice = $urandom_range(0, 9);
            if (choice < 7) begin
               // well-formed frame, mostly short
               len = ($urandom_range(0, 5) == 0) ? byte_type'($urandom_range(9, 40))
                                                 : byte_type'($urandom_range(0, 8));
               send_frame(byte_type'($urandom), len, len);
            end else if (choice < 9) begin
               // broken frame, cut short by whatever follows
               len = byte_type'($urandom_range(1, 255));
               send_frame(byte_type'($urandom), len, $urandom_range(0, (len < 6) ? len - 1 : 5));
            end else begin
               send_payload(byte_type'($urandom));
            end
         end
         quiet = 1'b0;
         wait_idle();
      end

      if (board.expected_beats.size() != 0) begin
         $display("%0d expected beats never arrived", board.expected_beats.size());
      end
      if (board.mismatches == 0 && board.expected_beats.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
